// ----- src/bss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Beep series sequencer package
// Shared sizes, request codes and the item and result types.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int TableDepth = 256;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int FreqW      = 16;
  localparam int TicksW     = 16;
  localparam int EntryW     = FreqW + TicksW;

  localparam logic [TicksW-1:0] BeepMaxTicks = TicksW'(20);

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_BEEP   = 2'd1,
    REQ_SERIES = 2'd2,
    REQ_STOP   = 2'd3
  } req_e;

  typedef struct packed {
    req_e              req;
    logic [FreqW-1:0]  freq;
    logic [TicksW-1:0] ticks;
    logic              last;
  } item_t;

  typedef struct packed {
    logic              tone_on;
    logic [FreqW-1:0]  freq;
    logic              tone_start;
    logic              tone_stop;
    logic              busy;
    logic              spk_req;
    logic              spk_rel;
  } res_t;

endpackage
`default_nettype wire

// ----- src/bss_tone_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tone table RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bss_tone_ram #(
  parameter int Depth = 256,
  parameter int Width = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- src/bss_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Beep series sequencer control
// Per-transaction sequencer: execute, table read with forwarding, commit.
// ----------------------------------------------------------------------------
module bss_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       beep_en_i,
  input  wire logic                       item_valid_i,
  output logic                            item_ready_o,
  input  wire bss_pkg::item_t             item_i,
  output logic                            res_valid_o,
  input  wire logic                       res_ready_i,
  output bss_pkg::res_t                   res_o,
  output logic                            mem_we_o,
  output logic [bss_pkg::AddrW-1:0]       mem_waddr_o,
  output logic [bss_pkg::EntryW-1:0]      mem_wdata_o,
  output logic                            mem_re_o,
  output logic [bss_pkg::AddrW-1:0]       mem_raddr_o,
  input  wire logic [bss_pkg::EntryW-1:0] mem_rdata_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    NEED_NONE,
    NEED_ADV,
    NEED_ARM
  } need_e;

  state_e                        state_q, state_d;
  need_e                         need_q, need_d;
  bss_pkg::item_t                item_q, item_d;
  logic [bss_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic [bss_pkg::CntW-1:0]      lp_q, lp_d;
  logic [bss_pkg::AddrW-1:0]     play_q, play_d;
  logic [bss_pkg::TicksW-1:0]    ticks_q, ticks_d;
  logic                          pend_q, pend_d;
  logic [bss_pkg::FreqW-1:0]     cur_q, cur_d;
  logic                          ok_q, ok_d;
  logic                          fwd_q, fwd_d;
  logic [bss_pkg::EntryW-1:0]    fwd_data_q, fwd_data_d;
  logic                          tstart_q, tstart_d;
  logic                          tstop_q, tstop_d;
  logic                          spreq_q, spreq_d;
  logic                          sprel_q, sprel_d;

  always_comb begin
    logic [bss_pkg::TicksW-1:0] dec;
    logic [bss_pkg::TicksW-1:0] dur;
    logic [bss_pkg::CntW-1:0]   lp_nxt;
    logic [bss_pkg::EntryW-1:0] ent;
    logic                       on;

    state_d      = state_q;
    need_d       = need_q;
    item_d       = item_q;
    cnt_d        = cnt_q;
    lp_d         = lp_q;
    play_d       = play_q;
    ticks_d      = ticks_q;
    pend_d       = pend_q;
    cur_d        = cur_q;
    ok_d         = ok_q;
    fwd_d        = fwd_q;
    fwd_data_d   = fwd_data_q;
    tstart_d     = tstart_q;
    tstop_d      = tstop_q;
    spreq_d      = spreq_q;
    sprel_d      = sprel_q;
    item_ready_o = 1'b0;
    res_valid_o  = 1'b0;
    res_o        = '0;
    mem_we_o     = 1'b0;
    mem_waddr_o  = '0;
    mem_wdata_o  = '0;
    mem_re_o     = 1'b0;
    mem_raddr_o  = '0;
    dec          = ticks_q - bss_pkg::TicksW'(1);
    dur          = (item_q.ticks > bss_pkg::BeepMaxTicks) ? bss_pkg::BeepMaxTicks
                                                          : item_q.ticks;
    lp_nxt       = lp_q;
    ent          = fwd_q ? fwd_data_q : mem_rdata_i;
    on           = 1'b0;

    case (state_q)
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          item_d  = item_i;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        need_d   = NEED_NONE;
        fwd_d    = 1'b0;
        tstart_d = 1'b0;
        tstop_d  = 1'b0;
        spreq_d  = 1'b0;
        sprel_d  = 1'b0;
        case (item_q.req)
          bss_pkg::REQ_TICK: begin
            if (ticks_q != '0) begin
              tstart_d = pend_q;
              pend_d   = 1'b0;
              ticks_d  = dec;
              if (dec == '0) begin
                need_d      = NEED_ADV;
                mem_re_o    = 1'b1;
                mem_raddr_o = play_q + bss_pkg::AddrW'(1);
                ok_d        = (bss_pkg::CntW'(play_q) + bss_pkg::CntW'(1)) < cnt_q;
              end
            end
          end
          bss_pkg::REQ_BEEP: begin
            if (beep_en_i && ticks_q == '0) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = '0;
              mem_wdata_o = {item_q.freq, dur};
              cnt_d       = bss_pkg::CntW'(1);
              play_d      = '0;
              lp_d        = '0;
              pend_d      = 1'b0;
              ticks_d     = dur;
              cur_d       = item_q.freq;
              tstart_d    = (dur != '0);
              spreq_d     = 1'b1;
            end
          end
          bss_pkg::REQ_SERIES: begin
            if (beep_en_i && ticks_q == '0) begin
              if (lp_q < bss_pkg::CntW'(bss_pkg::TableDepth - 1)) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = lp_q[bss_pkg::AddrW-1:0];
                mem_wdata_o = {item_q.freq, item_q.ticks};
                lp_nxt      = lp_q + bss_pkg::CntW'(1);
              end
              lp_d = lp_nxt;
              if (item_q.last) begin
                cnt_d       = lp_nxt;
                lp_d        = '0;
                play_d      = '0;
                need_d      = NEED_ARM;
                mem_re_o    = 1'b1;
                mem_raddr_o = '0;
                ok_d        = (lp_nxt != '0);
                // entry 0 written in this same cycle: bypass the RAM
                fwd_d       = mem_we_o && (lp_q == '0);
                fwd_data_d  = {item_q.freq, item_q.ticks};
              end
            end
          end
          bss_pkg::REQ_STOP: begin
            tstop_d = (ticks_q != '0) && !pend_q;
            cnt_d   = '0;
            play_d  = '0;
            ticks_d = '0;
            pend_d  = 1'b0;
            lp_d    = '0;
            sprel_d = 1'b1;
          end
          default: ;
        endcase
        state_d = ST_FIN;
      end

      ST_FIN: begin
        if (!ok_q) begin
          ent = '0;
        end
        case (need_q)
          NEED_ADV: begin
            tstop_d = 1'b1;
            if (ent[bss_pkg::EntryW-1:bss_pkg::TicksW] != '0 &&
                ent[bss_pkg::TicksW-1:0] != '0) begin
              play_d   = play_q + bss_pkg::AddrW'(1);
              ticks_d  = ent[bss_pkg::TicksW-1:0];
              cur_d    = ent[bss_pkg::EntryW-1:bss_pkg::TicksW];
              tstart_d = 1'b1;
            end else begin
              cnt_d   = '0;
              play_d  = '0;
              ticks_d = '0;
              pend_d  = 1'b0;
              sprel_d = 1'b1;
            end
          end
          NEED_ARM: begin
            ticks_d = ent[bss_pkg::TicksW-1:0];
            cur_d   = ent[bss_pkg::EntryW-1:bss_pkg::TicksW];
            pend_d  = (ent[bss_pkg::TicksW-1:0] != '0);
            spreq_d = 1'b1;
          end
          default: ;
        endcase
        on                = (ticks_d != '0) && !pend_d;
        res_o.tone_on     = on;
        res_o.freq        = on ? cur_d : '0;
        res_o.tone_start  = tstart_d;
        res_o.tone_stop   = tstop_d;
        res_o.busy        = (ticks_d != '0);
        res_o.spk_req     = spreq_d;
        res_o.spk_rel     = sprel_d;
        res_valid_o       = 1'b1;
        if (res_ready_i) begin
          need_d  = NEED_NONE;
          state_d = ST_IDLE;
        end else begin
          // hold until the output stage is free
          need_d   = need_q;
          play_d   = play_q;
          ticks_d  = ticks_q;
          cur_d    = cur_q;
          pend_d   = pend_q;
          cnt_d    = cnt_q;
          tstart_d = tstart_q;
          tstop_d  = tstop_q;
          spreq_d  = spreq_q;
          sprel_d  = sprel_q;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      need_q     <= NEED_NONE;
      item_q     <= '0;
      cnt_q      <= '0;
      lp_q       <= '0;
      play_q     <= '0;
      ticks_q    <= '0;
      pend_q     <= 1'b0;
      cur_q      <= '0;
      ok_q       <= 1'b0;
      fwd_q      <= 1'b0;
      fwd_data_q <= '0;
      tstart_q   <= 1'b0;
      tstop_q    <= 1'b0;
      spreq_q    <= 1'b0;
      sprel_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      need_q     <= need_d;
      item_q     <= item_d;
      cnt_q      <= cnt_d;
      lp_q       <= lp_d;
      play_q     <= play_d;
      ticks_q    <= ticks_d;
      pend_q     <= pend_d;
      cur_q      <= cur_d;
      ok_q       <= ok_d;
      fwd_q      <= fwd_d;
      fwd_data_q <= fwd_data_d;
      tstart_q   <= tstart_d;
      tstop_q    <= tstop_d;
      spreq_q    <= spreq_d;
      sprel_q    <= sprel_d;
    end
  end

endmodule
`default_nettype wire

// ----- src/beep_series_sequencer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// An input transaction is accepted, executed, then committed to the output register.
// One transaction is in flight at a time; it is taken through accept, execute with table
//   write and read, and commit before another is accepted.
//   A full output register with m_axis_tready low holds the commit cycle.
// Reset: control state cleared, beeps enabled; the tone table is not cleared
//   and its contents are undefined until written.
// ----------------------------------------------------------------------------
// Beep series sequencer top level
// Stream ports, configuration register, table RAM and output register.
// ----------------------------------------------------------------------------
module beep_series_sequencer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,    // beep_enabled
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // tone_freq[15:0], tone_ticks[31:16]
  input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
  input  wire logic        s_axis_tlast,   // last_entry
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata    // tone_on[0], tone_freq_out[16:1],
                                           // tone_start[17], tone_stop[18],
                                           // busy_res[19], speaker_request[20],
                                           // speaker_release[21], zero[23:22]
);

  logic                         beep_en_q;
  bss_pkg::item_t               item;
  logic                         res_valid;
  logic                         res_ready;
  bss_pkg::res_t                res;
  logic                         mem_we;
  logic [bss_pkg::AddrW-1:0]    mem_waddr;
  logic [bss_pkg::EntryW-1:0]   mem_wdata;
  logic                         mem_re;
  logic [bss_pkg::AddrW-1:0]    mem_raddr;
  logic [bss_pkg::EntryW-1:0]   mem_rdata;
  logic                         out_valid_q;
  logic [23:0]                  out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beep_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      beep_en_q <= cfg_wdata_i;
    end
  end

  assign item.req   = bss_pkg::req_e'(s_axis_tuser);
  assign item.freq  = s_axis_tdata[15:0];
  assign item.ticks = s_axis_tdata[31:16];
  assign item.last  = s_axis_tlast;

  bss_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beep_en_i    (beep_en_q),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_i       (item),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  bss_tone_ram #(
    .Depth (bss_pkg::TableDepth),
    .Width (bss_pkg::EntryW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= {2'b00, res.spk_rel, res.spk_req, res.busy, res.tone_stop,
                     res.tone_start, res.freq, res.tone_on};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second transaction accepted while one is in flight");

  a_on_is_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[19])
    else $error("tone sounding with no remaining duration");

  a_silent_freq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[16:1] == '0)
    else $error("frequency reported while no tone sounds");

  a_req_rel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[20] && m_axis_tdata[21]))
    else $error("speaker request and release in one result");
`endif

endmodule
`default_nettype wire
